>>> rtl/core/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder: payload structs, controller state,
// command and status structs, and byte-classification constants. No dependencies.
package utf8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int QDEPTH   = 3;
    localparam int MAX_RES  = 4;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_L2     = 8'hE0;
    localparam logic [7:0] CODE_L2     = 8'hC0;
    localparam logic [7:0] MASK_L3     = 8'hF0;
    localparam logic [7:0] CODE_L3     = 8'hE0;
    localparam logic [7:0] MASK_L4     = 8'hF8;
    localparam logic [7:0] CODE_L4     = 8'hF0;
    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] CODE_CONT   = 8'h80;
    localparam logic [CP_W-1:0] REPL_CP = 21'h00003F;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            was_replaced;
        logic            final_result;
    } out_t;

    typedef enum logic {
        ST_STREAM,
        ST_REPLAY
    } state_t;

    typedef struct packed {
        logic step;
        logic from_input;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic queue_busy;
        logic queue_after;
    } status_t;

endpackage

>>> rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level: joins the controller and the datapath.
// Latency: a result appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output is not stalled; a bad continuation
// holds off the input while the queued bytes are replayed.
// Reset: aresetn is synchronous and active low; it empties the sequence buffer,
// the replay queue and the output register. Depends on utf8sd_pkg.
module utf8_stream_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  utf8sd_pkg::in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output utf8sd_pkg::out_t m_data
);
    import utf8sd_pkg::*;

    cmd_t    cmd;
    status_t sts;
    state_t  state;

    // The controller decides each cycle whether the decode step runs and
    // whether it consumes the incoming byte or the head of the replay queue.
    utf8sd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    // The datapath holds the open sequence, the bytes awaiting replay after
    // a bad continuation, and the registered result that parts the two sides.
    utf8sd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // While replaying, the queue must hold at least one byte.
    a_replay_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_REPLAY) |-> sts.queue_busy)
        else $error("replay state with an empty queue");

    // No new transaction is taken while queued bytes are still to be replayed.
    a_no_accept_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.queue_busy |-> !s_ready)
        else $error("input accepted during replay");

    // A held result is never overwritten by a decode step.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.step)
        else $error("decode step while output is stalled");

endmodule

>>> rtl/core/utf8sd_ctrl.sv
// Controller for the UTF-8 stream decoder: chooses between taking a new byte
// and replaying queued bytes. Depends on utf8sd_pkg.
module utf8sd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  utf8sd_pkg::status_t sts,
    output utf8sd_pkg::cmd_t    cmd,
    output utf8sd_pkg::state_t  state
);
    import utf8sd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_STREAM;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: after any step, go to or stay in replay while bytes remain queued, else stream.
    always_comb begin
        state_next = state_reg;
        if (cmd.step) begin
            state_next = sts.queue_after ? ST_REPLAY : ST_STREAM;
        end
    end

    always_comb begin
        cmd.from_input = 1'b0;
        cmd.step       = 1'b0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_STREAM: begin
                cmd.from_input = 1'b1;
                s_ready        = sts.out_free;
                cmd.step       = sts.out_free && s_valid;
            end
            ST_REPLAY: begin
                cmd.step = sts.out_free;
            end
            default: begin
                cmd.step = 1'b0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

>>> rtl/core/utf8sd_datapath.sv
// Datapath for the UTF-8 stream decoder: sequence buffer, replay queue,
// decode logic and the output register. Depends on utf8sd_pkg.
module utf8sd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  utf8sd_pkg::in_t     s_data,
    input  utf8sd_pkg::cmd_t    cmd,
    output utf8sd_pkg::status_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output utf8sd_pkg::out_t    m_data
);
    import utf8sd_pkg::*;

    logic [BYTE_W-1:0] pend_reg [QDEPTH];
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [2:0]        slen_reg, slen_next;
    logic [BYTE_W-1:0] q_reg [QDEPTH];
    logic [BYTE_W-1:0] q_next [QDEPTH];
    logic [1:0]        qlen_reg, qlen_next;
    logic              qlast_reg;
    logic [2:0]        rcnt_reg, rcnt_next;
    logic              mvalid_reg;
    out_t              out_reg;

    logic [BYTE_W-1:0] cur_byte;
    logic              cur_last;
    logic              emit, emit_ok, fail, pend_wr;
    logic [1:0]        pend_idx;
    out_t              emit_val;
    logic [1:0]        rlen, rest_cnt;
    logic [BYTE_W-1:0] rbytes [QDEPTH];
    logic [2:0]        src_idx;
    logic              cont_ok;
    logic [CP_W-1:0]   asm_cp;

    assign cur_byte = cmd.from_input ? s_data.text_byte : q_reg[0];
    assign cur_last = cmd.from_input ? s_data.end_of_text
                                     : (qlast_reg && (qlen_reg == 2'd1));

    // Assembly and continuation check of a completed sequence.
    always_comb begin
        asm_cp  = '0;
        cont_ok = 1'b0;
        rbytes[0] = cur_byte;
        rbytes[1] = cur_byte;
        rbytes[2] = cur_byte;
        unique case (slen_reg)
            LEN_3: begin
                asm_cp  = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], cur_byte[5:0]};
                cont_ok = ((pend_reg[1] & MASK_CONT) == CODE_CONT)
                       && ((cur_byte & MASK_CONT) == CODE_CONT);
                rbytes[0] = pend_reg[1];
            end
            LEN_4: begin
                asm_cp  = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                           cur_byte[5:0]};
                cont_ok = ((pend_reg[1] & MASK_CONT) == CODE_CONT)
                       && ((pend_reg[2] & MASK_CONT) == CODE_CONT)
                       && ((cur_byte & MASK_CONT) == CODE_CONT);
                rbytes[0] = pend_reg[1];
                rbytes[1] = pend_reg[2];
            end
            default: begin
                asm_cp  = {10'd0, pend_reg[0][4:0], cur_byte[5:0]};
                cont_ok = ((cur_byte & MASK_CONT) == CODE_CONT);
            end
        endcase
    end

    // One byte fed through the decoder.
    always_comb begin
        emit      = 1'b0;
        emit_val  = '{code_point: REPL_CP, was_replaced: 1'b1, final_result: cur_last};
        fail      = 1'b0;
        pend_wr   = 1'b0;
        pend_idx  = 2'd0;
        pcnt_next = pcnt_reg;
        slen_next = slen_reg;
        if (slen_reg == LEN_NONE) begin
            if (cur_byte < ASCII_LIMIT) begin
                emit     = 1'b1;
                emit_val = '{code_point: {13'd0, cur_byte}, was_replaced: 1'b0,
                             final_result: cur_last};
            end else if ((cur_byte & MASK_L2) == CODE_L2 ||
                         (cur_byte & MASK_L3) == CODE_L3 ||
                         (cur_byte & MASK_L4) == CODE_L4) begin
                if (cur_last) begin
                    emit = 1'b1;
                end else begin
                    pend_wr   = 1'b1;
                    pcnt_next = 2'd1;
                    if ((cur_byte & MASK_L2) == CODE_L2) begin
                        slen_next = LEN_2;
                    end else if ((cur_byte & MASK_L3) == CODE_L3) begin
                        slen_next = LEN_3;
                    end else begin
                        slen_next = LEN_4;
                    end
                end
            end else begin
                emit = 1'b1;
            end
        end else if (({1'b0, pcnt_reg} + 3'd1) < slen_reg) begin
            if (cur_last || pcnt_reg == 2'd3) begin
                emit      = 1'b1;
                pcnt_next = 2'd0;
                slen_next = LEN_NONE;
            end else begin
                pend_wr   = 1'b1;
                pend_idx  = pcnt_reg;
                pcnt_next = pcnt_reg + 2'd1;
            end
        end else begin
            pcnt_next = 2'd0;
            slen_next = LEN_NONE;
            emit      = 1'b1;
            if (cont_ok) begin
                emit_val = '{code_point: asm_cp, was_replaced: 1'b0,
                             final_result: cur_last};
            end else begin
                fail     = 1'b1;
                emit_val = '{code_point: REPL_CP, was_replaced: 1'b1,
                             final_result: 1'b0};
            end
        end
    end

    assign emit_ok = emit && (cmd.from_input || rcnt_reg < 3'(MAX_RES));

    // Replay queue: bytes after a failed lead go in front of what remains.
    always_comb begin
        rlen     = fail ? 2'(slen_reg - 3'd1) : 2'd0;
        rest_cnt = cmd.from_input ? 2'd0 : (qlen_reg - 2'd1);
        qlen_next = rlen + rest_cnt;
        src_idx  = '0;
        for (int i = 0; i < QDEPTH; i++) begin
            q_next[i] = '0;
            if (2'(i) < rlen) begin
                q_next[i] = rbytes[i];
            end else begin
                src_idx = 3'(i) - {1'b0, rlen} + 3'd1;
                if (src_idx < 3'(QDEPTH)) begin
                    q_next[i] = q_reg[src_idx[1:0]];
                end
            end
        end
    end

    always_comb begin
        rcnt_next = rcnt_reg;
        if (cmd.from_input) begin
            rcnt_next = emit ? 3'd1 : 3'd0;
        end else if (emit_ok) begin
            rcnt_next = rcnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg   <= 2'd0;
            slen_reg   <= LEN_NONE;
            qlen_reg   <= 2'd0;
            rcnt_reg   <= 3'd0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cmd.step) begin
                pcnt_reg <= pcnt_next;
                slen_reg <= slen_next;
                qlen_reg <= qlen_next;
                rcnt_reg <= rcnt_next;
            end
            if (cmd.step && emit_ok) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (pend_wr) begin
                pend_reg[pend_idx] <= cur_byte;
            end
            for (int i = 0; i < QDEPTH; i++) begin
                q_reg[i] <= q_next[i];
            end
            if (cmd.from_input) begin
                qlast_reg <= s_data.end_of_text;
            end
            if (emit_ok) begin
                out_reg <= emit_val;
            end
        end
    end

    assign sts.out_free    = !mvalid_reg || m_ready;
    assign sts.queue_busy  = (qlen_reg != 2'd0);
    assign sts.queue_after = (qlen_next != 2'd0);
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

endmodule
